FILE: rtl/core/cscan_disk_scheduler_unit_defines.svh
// Assertion macros for the C-SCAN scheduler.
`ifndef CSCAN_DISK_SCHEDULER_UNIT_DEFINES_SVH
`define CSCAN_DISK_SCHEDULER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define CSCAN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CSCAN_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CSCAN_ASSERT(lbl, prop, msg)
`define CSCAN_NEVER(lbl, expr, msg)
`endif

`endif

FILE: rtl/core/cscan_pkg.sv
package cscan_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_W      = 16;
  localparam int ADDR_W       = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int EMIT_W       = $clog2(MAX_REQUESTS + 3);
  localparam int TOTAL_W      = 22;
  localparam int REQ_COUNT_W  = 6;
  localparam int CFG_IDX_W    = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_POSITION = 1'b0,
    REG_END_TRACK     = 1'b1
  } cfg_reg_t;

endpackage

FILE: rtl/core/cscan_disk_scheduler_unit.sv
// C-SCAN disk scheduler. Requests are taken one per cycle with start while busy
// is low; the request flagged by last_request closes the batch, and the block
// raises busy and plays out the schedule: upward from head_position through the
// requests at or above it to end_track, a return jump to track 0, then upward
// through the requests below the head. A batch of n requests (at most 32, more
// are dropped) gives n + 2 moves, each shown for one cycle with strobe; the
// receiver cannot stall, so it must take every strobe. Each move takes a set-up
// state (ST_INIT) and then a full pass over the request memory through its
// single read port (ST_SCAN). busy is low again during the cycle of the final
// move, and the next batch may start there. Write head_position and end_track
// only while busy is low.
`include "cscan_disk_scheduler_unit_defines.svh"

module cscan_disk_scheduler_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cscan_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cscan_pkg::TRACK_W-1:0]       cfg_data,
  input  logic                                start,
  output logic                                busy,
  input  logic [cscan_pkg::TRACK_W-1:0]       track,
  input  logic                                last_request,
  output logic                                strobe,
  output logic [cscan_pkg::TRACK_W-1:0]       from_track,
  output logic [cscan_pkg::TRACK_W-1:0]       to_track,
  output logic [cscan_pkg::TRACK_W-1:0]       seek_distance,
  output logic                                return_jump,
  output logic [cscan_pkg::TOTAL_W-1:0]       seek_sum,
  output logic [cscan_pkg::REQ_COUNT_W-1:0]   request_count,
  output logic                                last_move
);
  import cscan_pkg::*;

  state_t              state, state_next;
  logic [TRACK_W-1:0]  head_position, end_track;
  logic [CNT_W-1:0]    cnt;
  logic [EMIT_W-1:0]   emit_cnt;
  logic [CNT_W-1:0]    iss;
  logic                rd_vld;
  logic [CNT_W-1:0]    rd_idx;
  logic [TRACK_W-1:0]  rd_data;
  logic                phase_high;
  logic                prev_vld;
  logic [TRACK_W-1:0]  prev_val;
  logic [CNT_W-1:0]    prev_idx;
  logic                best_vld;
  logic [TRACK_W-1:0]  best_val;
  logic [CNT_W-1:0]    best_idx;
  logic [TRACK_W-1:0]  cur;
  logic [TOTAL_W-1:0]  total;
  logic [TRACK_W-1:0]  mem [0:MAX_REQUESTS-1];

  logic                accept, load_wr, issue, scan_done;
  logic                in_set, gt_prev, lt_best, take, end_gt_prev;
  logic [TRACK_W-1:0]  emit_to, move_dist;
  logic                emit_wrap, emit_last;
  logic [TOTAL_W-1:0]  total_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && last_request) state_next = ST_INIT;
      ST_INIT: state_next = ST_SCAN;
      ST_SCAN: if (scan_done) state_next = emit_last ? ST_IDLE : ST_INIT;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    accept    = start && (state == ST_IDLE);
    load_wr   = accept && (cnt < CNT_W'(MAX_REQUESTS));
    issue     = (state == ST_SCAN) && (iss < cnt);
    scan_done = (state == ST_SCAN) && (iss == cnt) && !rd_vld;
  end

  // candidate selection: smallest (track, index) above the last served key
  always_comb begin
    in_set      = phase_high ? (rd_data >= head_position) : (rd_data < head_position);
    gt_prev     = !prev_vld || (rd_data > prev_val) ||
                  ((rd_data == prev_val) && (rd_idx > prev_idx));
    lt_best     = !best_vld || (rd_data < best_val) ||
                  ((rd_data == best_val) && (rd_idx < best_idx));
    take        = rd_vld && in_set && gt_prev && lt_best;
    end_gt_prev = !prev_vld || (end_track > prev_val);
    emit_wrap   = phase_high && !best_vld;
    emit_to     = emit_wrap ? '0 : best_val;
    move_dist   = (cur > emit_to) ? (cur - emit_to) : (emit_to - cur);
    total_next  = total + TOTAL_W'(move_dist);
    emit_last   = (emit_cnt == (EMIT_W'(cnt) + EMIT_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem[cnt[ADDR_W-1:0]] <= track;
    end
    if (issue) begin
      rd_data <= mem[iss[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head_position <= '0;
      end_track     <= '1;
      cnt           <= '0;
      rd_vld        <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= scan_done;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEAD_POSITION: head_position <= cfg_data;
          REG_END_TRACK:     end_track     <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (load_wr) cnt <= cnt + CNT_W'(1);
          if (accept && last_request) begin
            phase_high <= 1'b1;
            prev_vld   <= 1'b0;
            emit_cnt   <= '0;
            total      <= '0;
            cur        <= head_position;
          end
        end
        ST_INIT: begin
          iss      <= '0;
          rd_vld   <= 1'b0;
          best_vld <= phase_high && end_gt_prev;
          best_val <= end_track;
          best_idx <= '0;
        end
        ST_SCAN: begin
          rd_vld <= issue;
          rd_idx <= iss + CNT_W'(1);
          if (issue) iss <= iss + CNT_W'(1);
          if (take) begin
            best_vld <= 1'b1;
            best_val <= rd_data;
            best_idx <= rd_idx;
          end
          if (scan_done) begin
            from_track    <= cur;
            to_track      <= emit_to;
            seek_distance <= move_dist;
            return_jump   <= emit_wrap;
            seek_sum      <= total_next;
            request_count <= emit_last ? REQ_COUNT_W'(cnt) : '0;
            last_move     <= emit_last;
            cur           <= emit_to;
            total         <= total_next;
            emit_cnt      <= emit_cnt + EMIT_W'(1);
            if (emit_wrap) begin
              phase_high <= 1'b0;
              prev_vld   <= 1'b0;
            end else begin
              prev_vld <= 1'b1;
              prev_val <= best_val;
              prev_idx <= best_idx;
            end
            if (emit_last) cnt <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `CSCAN_ASSERT(a_last_frees, strobe && last_move |-> !busy, "busy after final move")
  `CSCAN_ASSERT(a_mid_busy, strobe && !last_move |-> busy, "idle before final move")
  `CSCAN_ASSERT(a_strobe_gap, strobe |=> !strobe, "moves on adjacent cycles")
  `CSCAN_NEVER(a_busy_empty, busy && (cnt == '0), "schedule with empty batch")
  `CSCAN_NEVER(a_emit_bound, busy && (emit_cnt > (EMIT_W'(cnt) + EMIT_W'(1))), "too many moves")

endmodule
